[rtl/ucodec_pkg.sv]
// Shared types and constants for the URL percent codec.
// No dependencies; imported by ucodec_step and url_percent_codec_top.
`default_nettype none

package ucodec_pkg;

    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    // 'a' - 10: subtracting it maps 'a'..'f' onto 10..15.
    localparam logic [7:0] HEX_LETTER_OFFSET = 8'd87;
    localparam logic [7:0] CASE_OFFSET       = 8'h20;

    localparam logic      DIR_ENCODE = 1'b0;
    localparam logic      DIR_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ESC_IDLE   = 2'd0,
        ESC_FIRST  = 2'd1,
        ESC_SECOND = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_char;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] items;
        esc_phase_t    phase_next;
        logic [3:0]    nibble_next;
    } step_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        case (nib)
            4'h0: ch = 8'h30;
            4'h1: ch = 8'h31;
            4'h2: ch = 8'h32;
            4'h3: ch = 8'h33;
            4'h4: ch = 8'h34;
            4'h5: ch = 8'h35;
            4'h6: ch = 8'h36;
            4'h7: ch = 8'h37;
            4'h8: ch = 8'h38;
            4'h9: ch = 8'h39;
            4'hA: ch = 8'h61;
            4'hB: ch = 8'h62;
            4'hC: ch = 8'h63;
            4'hD: ch = 8'h64;
            4'hE: ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/url_percent_codec_top.sv]
// Top level of the URL percent codec: input register, escape state,
// result sequencer and output register. Uses ucodec_pkg and ucodec_step.
//
// Byte-stream URL form codec. With direction 0 it encodes: letters, digits
// and - _ . ~ pass, space becomes '+', any other byte becomes '%' and two
// lower-case hex digits. With direction 1 it decodes '+' to space and
// '%'-escapes to bytes (digits are not checked). The final byte of a string
// always yields a result with m_out_last set; m_has_char is low on a bare end
// marker. A plain byte yields one result and an escaped byte three when
// encoding; an escape byte that produces nothing when decoding retires at once.
// An accepted byte waits in the input register until its last result has been
// loaded into the single result register, which holds one result at a time,
// so a stalled result channel holds off the input. Change direction only while
// the block is idle; the escape state survives a write.
`default_nettype none

module url_percent_codec_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_has_char,
    output logic            m_out_last
);
    import ucodec_pkg::*;

    logic       direction_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    esc_phase_t phase_reg;
    logic [3:0] nibble_reg;
    logic [1:0] idx_reg;
    logic       m_valid_reg;
    result_t    m_data_reg;

    step_t      step;
    result_t    cur_result;
    logic       out_free;
    logic       out_load;
    logic       item_done;

    ucodec_step u_step (
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .direction (direction_reg),
        .phase     (phase_reg),
        .nibble    (nibble_reg),
        .step      (step)
    );

    always_comb begin
        case (idx_reg)
            2'd0:    cur_result = step.items[0];
            2'd1:    cur_result = step.items[1];
            default: cur_result = step.items[2];
        endcase
        out_free  = !m_valid_reg || m_ready;
        out_load  = in_valid_reg && (step.count != 2'd0) && out_free;
        // The item retires with its last result, or at once if it has none.
        item_done = in_valid_reg && ((step.count == 2'd0)
                    || (out_free && (idx_reg == step.count - 2'd1)));
        s_ready   = !in_valid_reg || item_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            in_valid_reg  <= 1'b0;
            phase_reg     <= ESC_IDLE;
            nibble_reg    <= 4'd0;
            idx_reg       <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (item_done) begin
                in_valid_reg <= 1'b0;
            end
            if (item_done) begin
                phase_reg  <= step.phase_next;
                nibble_reg <= step.nibble_next;
                idx_reg    <= 2'd0;
            end else if (out_load) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
        if (out_load) begin
            m_data_reg <= cur_result;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_data_reg.data;
    assign m_has_char = m_data_reg.has_char;
    assign m_out_last = m_data_reg.last;

endmodule

`default_nettype wire

[rtl/ucodec_step.sv]
// Combinational step of the URL codec: one byte plus escape state in,
// up to three result characters and the next escape state out. Uses ucodec_pkg.
`default_nettype none

module ucodec_step (
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    input  wire logic                   direction,
    input  wire ucodec_pkg::esc_phase_t phase,
    input  wire logic [3:0]             nibble,
    output ucodec_pkg::step_t           step
);
    import ucodec_pkg::*;

    logic       is_digit;
    logic       is_upper;
    logic       is_plain;
    logic [7:0] lowered;
    logic [7:0] digit_val;

    always_comb begin
        is_digit = (in_byte inside {[CHAR_ZERO:CHAR_NINE]});
        is_upper = (in_byte inside {[CHAR_UP_A:CHAR_UP_Z]});
        is_plain = is_digit || is_upper || (in_byte inside {[CHAR_LOW_A:CHAR_LOW_Z]})
                   || (in_byte inside {CHAR_MINUS, CHAR_UNDER, CHAR_DOT, CHAR_TILDE});
        lowered   = is_upper ? (in_byte + CASE_OFFSET) : in_byte;
        digit_val = is_digit ? (in_byte - CHAR_ZERO) : (lowered - HEX_LETTER_OFFSET);
    end

    always_comb begin
        step             = '0;
        step.phase_next  = phase;
        step.nibble_next = nibble;

        if (direction == DIR_ENCODE) begin
            step.phase_next  = ESC_IDLE;
            step.nibble_next = 4'd0;
            if (is_plain) begin
                step.count    = 2'd1;
                step.items[0] = '{data: in_byte, has_char: 1'b1, last: in_last};
            end else if (in_byte == CHAR_SPACE) begin
                step.count    = 2'd1;
                step.items[0] = '{data: CHAR_PLUS, has_char: 1'b1, last: in_last};
            end else begin
                step.count    = 2'd3;
                step.items[0] = '{data: CHAR_PERCENT, has_char: 1'b1, last: 1'b0};
                step.items[1] = '{data: hex_char(in_byte[7:4]), has_char: 1'b1,
                                  last: 1'b0};
                step.items[2] = '{data: hex_char(in_byte[3:0]), has_char: 1'b1,
                                  last: in_last};
            end
        end else begin
            case (phase)
                ESC_FIRST: begin
                    step.nibble_next = digit_val[3:0];
                    step.phase_next  = ESC_SECOND;
                end
                ESC_SECOND: begin
                    step.phase_next  = ESC_IDLE;
                    step.nibble_next = 4'd0;
                    step.count       = 2'd1;
                    step.items[0]    = '{data: {nibble, 4'd0} | digit_val, has_char: 1'b1,
                                         last: in_last};
                end
                default: begin
                    if (in_byte == CHAR_PERCENT) begin
                        step.phase_next  = ESC_FIRST;
                        step.nibble_next = 4'd0;
                    end else begin
                        step.phase_next = ESC_IDLE;
                        step.count      = 2'd1;
                        step.items[0]   = '{data: (in_byte == CHAR_PLUS) ? CHAR_SPACE
                                                                          : in_byte,
                                            has_char: 1'b1, last: in_last};
                    end
                end
            endcase

            // An escape left open at the end of a string is dropped; only the
            // end marker goes out.
            if (step.count == 2'd0 && in_last) begin
                step.phase_next  = ESC_IDLE;
                step.nibble_next = 4'd0;
                step.count       = 2'd1;
                step.items[0]    = '{data: 8'd0, has_char: 1'b0, last: 1'b1};
            end
        end
    end

endmodule

`default_nettype wire

[sim/url_percent_codec_checker.sv]
// Scoreboard for the URL percent codec: watches the config port and both channels,
// predicts the result characters of every accepted byte and compares them in order.
// Depends on ucodec_pkg for the result type, escape phases and character constants.
`timescale 1ns / 100ps

module url_percent_codec_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_has_char,
    input  logic       m_out_last,
    output int         mismatch_count,
    output int         results_pending
);
    import ucodec_pkg::*;

    result_t    expected_chars[$];
    logic       direction;
    esc_phase_t esc_phase;
    logic [3:0] high_nib;
    int         errors;

    initial begin
        mismatch_count = 0;
        results_pending = 0;
        errors = 0;
        direction = DIR_ENCODE;
        esc_phase = ESC_IDLE;
        high_nib = 4'h0;
    end

    function automatic bit url_safe(input logic [7:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
            || (c >= CHAR_UP_A && c <= CHAR_UP_Z) || c == CHAR_MINUS || c == CHAR_UNDER
            || c == CHAR_DOT || c == CHAR_TILDE;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? CHAR_ZERO + 8'(n) : HEX_LETTER_OFFSET + 8'(n);
    endfunction

    // Digits are not validated: anything outside 0-9 is lower-cased (ASCII letters only)
    // and offset as if it were a-f, wrapping at 8 bits.
    function automatic logic [7:0] hex_value_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return c - CHAR_ZERO;
        end
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            lc = c + CASE_OFFSET;
        end
        return lc - HEX_LETTER_OFFSET;
    endfunction

    task automatic expect_char(input logic [7:0] d, input logic h, input logic l);
        expected_chars.push_back('{data: d, has_char: h, last: l});
    endtask

    task automatic predict_chars(input logic [7:0] c, input logic lst);
        logic [7:0] v;
        if (direction == DIR_ENCODE) begin
            esc_phase = ESC_IDLE;
            high_nib = 4'h0;
            if (url_safe(c)) begin
                expect_char(c, 1'b1, lst);
            end else if (c == CHAR_SPACE) begin
                expect_char(CHAR_PLUS, 1'b1, lst);
            end else begin
                expect_char(CHAR_PERCENT, 1'b1, 1'b0);
                expect_char(nibble_char(c[7:4]), 1'b1, 1'b0);
                expect_char(nibble_char(c[3:0]), 1'b1, lst);
            end
            return;
        end
        case (esc_phase)
            ESC_FIRST: begin
                v = hex_value_of(c);
                high_nib = v[3:0];
                esc_phase = ESC_SECOND;
            end
            ESC_SECOND: begin
                v = {high_nib, 4'h0} | hex_value_of(c);
                esc_phase = ESC_IDLE;
                high_nib = 4'h0;
                expect_char(v, 1'b1, lst);
                return;
            end
            default: begin
                if (c == CHAR_PERCENT) begin
                    esc_phase = ESC_FIRST;
                    high_nib = 4'h0;
                end else begin
                    esc_phase = ESC_IDLE;
                    expect_char((c == CHAR_PLUS) ? CHAR_SPACE : c, 1'b1, lst);
                    return;
                end
            end
        endcase
        // An escape cut short by the end of the string leaves only a bare end marker.
        if (lst) begin
            esc_phase = ESC_IDLE;
            high_nib = 4'h0;
            expect_char(8'h00, 1'b0, 1'b1);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: unexpected result byte %02h has_char %0b last %0b",
                         $realtime, m_out_byte, m_has_char, m_out_last);
            end
            return;
        end
        want = expected_chars.pop_front();
        if (m_out_byte !== want.data || m_has_char !== want.has_char
                || m_out_last !== want.last) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                         $realtime, want.data, want.has_char, want.last,
                         m_out_byte, m_has_char, m_out_last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
            direction = DIR_ENCODE;
            esc_phase = ESC_IDLE;
            high_nib = 4'h0;
        end else begin
            if (cfg_wr_en) begin
                direction = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                predict_chars(s_in_byte, s_in_last);
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        results_pending <= expected_chars.size();
        mismatch_count <= errors;
    end

endmodule

[sim/url_percent_codec_top_tb.sv]
// Testbench top for the URL percent codec: clock, reset, config writes, byte stimulus
// and a randomly stalling result sink. Depends on ucodec_pkg, url_percent_codec_top
// and url_percent_codec_checker.
`timescale 1ns / 100ps

module url_percent_codec_top_tb;
    import ucodec_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD_CYCLES = 80;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_in_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_has_char;
    logic       m_out_last;
    int         mismatch_count;
    int         results_pending;

    logic [7:0] str_bytes[$];
    bit         tx_burst = 1'b0;
    bit         long_hold_req = 1'b0;
    int         idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    url_percent_codec_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_char  (m_has_char),
        .m_out_last  (m_out_last)
    );

    url_percent_codec_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_in_last       (s_in_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_has_char      (m_has_char),
        .m_out_last      (m_out_last),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result sink: random stall before each transfer, with stretches of none, and one
    // long hold-off that lets the block back up into its input.
    initial begin : result_sink
        int  stall;
        bit  rx_burst;
        stall = 0;
        rx_burst = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                stall = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else if (m_valid && m_ready) begin
                if ($urandom_range(0, 15) == 0) begin
                    rx_burst = !rx_burst;
                end
                stall = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic lst);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= c;
        s_in_last <= lst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < str_bytes.size(); i++) begin
            send_item(str_bytes[i], i == str_bytes.size() - 1);
        end
        if ($urandom_range(0, 3) == 0) begin
            tx_burst = !tx_burst;
        end
    endtask

    // Waits until every predicted result has been seen, lets a byte that yields nothing
    // drain, then writes the register.
    task automatic set_direction(input logic d);
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (6) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_digit();
        logic [7:0] c;
        int         n;
        n = $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        if (n < 10) begin
            return CHAR_ZERO + 8'(n);
        end
        c = HEX_LETTER_OFFSET + 8'(n);
        return $urandom_range(0, 1) ? c - CASE_OFFSET : c;
    endfunction

    task automatic random_phase(input logic d, input int n, input bit with_hold);
        int         sent;
        int         r;
        logic [7:0] c;
        set_direction(d);
        if (with_hold) begin
            long_hold_req = 1'b1;
        end
        sent = 0;
        while (sent < n) begin
            str_bytes.delete();
            if (d == DIR_ENCODE) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 5);
                    if (r == 0) begin
                        c = CHAR_SPACE;
                    end else if (r == 1) begin
                        c = CHAR_LOW_A + 8'($urandom_range(0, 25));
                    end else begin
                        c = 8'($urandom_range(0, 255));
                    end
                    str_bytes.push_back(c);
                end
            end else begin
                // Mostly well-formed escapes and pass-through bytes, with some noise.
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 9);
                    if (r < 5) begin
                        str_bytes.push_back(CHAR_PERCENT);
                        str_bytes.push_back(rand_hex_digit());
                        str_bytes.push_back(rand_hex_digit());
                    end else if (r == 5) begin
                        str_bytes.push_back(CHAR_PLUS);
                    end else begin
                        c = 8'($urandom_range(0, 255));
                        if (r < 9 && c == CHAR_PERCENT) begin
                            c = CHAR_PLUS;
                        end
                        str_bytes.push_back(c);
                    end
                end
                if ($urandom_range(0, 5) == 0) begin
                    str_bytes.push_back(CHAR_PERCENT);
                    if ($urandom_range(0, 1) == 1) begin
                        str_bytes.push_back(rand_hex_digit());
                    end
                end
            end
            sent += str_bytes.size();
            send_string();
        end
    endtask

    initial begin : stimulus
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= DIR_ENCODE;
        s_valid <= 1'b0;
        s_in_byte <= 8'h00;
        s_in_last <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Encoding: escaped extremes, plain characters and the space substitution.
        set_direction(DIR_ENCODE);
        send_item(8'h00, 1'b0);
        send_item(CHAR_UP_Z, 1'b0);
        send_item(CHAR_SPACE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CHAR_TILDE, 1'b1);

        // Decoding: lower- and upper-case escapes, plus, and high bytes used as digits.
        set_direction(DIR_DECODE);
        send_item(CHAR_PERCENT, 1'b0);
        send_item(CHAR_ZERO + 8'd4, 1'b0);
        send_item(CHAR_LOW_A, 1'b0);
        send_item(CHAR_PLUS, 1'b0);
        send_item(CHAR_PERCENT, 1'b0);
        send_item(CHAR_UP_A + 8'd5, 1'b0);
        send_item(CHAR_LOW_A + 8'd5, 1'b1);
        send_item(CHAR_PERCENT, 1'b0);
        send_item(8'hC1, 1'b0);
        send_item(8'h80, 1'b1);

        // Strings that end inside an escape produce only an end marker.
        send_item(CHAR_PERCENT, 1'b1);
        send_item(CHAR_PERCENT, 1'b0);
        send_item(CHAR_ZERO + 8'd7, 1'b1);

        // A register write in the middle of an escape must not disturb it.
        send_item(CHAR_PERCENT, 1'b0);
        set_direction(DIR_DECODE);
        send_item(CHAR_ZERO + 8'd4, 1'b0);
        send_item(CHAR_ZERO + 8'd1, 1'b1);

        // An encoded byte in between clears a half-received escape.
        send_item(CHAR_PERCENT, 1'b0);
        send_item(CHAR_ZERO + 8'd4, 1'b0);
        set_direction(DIR_ENCODE);
        send_item(CHAR_SPACE, 1'b1);
        set_direction(DIR_DECODE);
        send_item(CHAR_ZERO + 8'd1, 1'b1);

        random_phase(DIR_ENCODE, 20, 1'b1);
        random_phase(DIR_DECODE, 30, 1'b0);
        random_phase(DIR_ENCODE, 8, 1'b0);
        random_phase(DIR_DECODE, 15, 1'b0);

        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
